@@ sv/tspc_pkg.sv @@
// Package for the trapezoid speed profile block: types, constants and numerator helpers.
`default_nettype none

package tspc_pkg;

    // Widths of configuration data and arithmetic
    localparam int TICK_BITS_DEF = 16;
    localparam int CFG_W         = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int SPD_W         = 13;
    localparam int NUM_W         = 29;
    localparam int STEP_W        = 4;

    // Index of the last step of each shift-add multiply and each restoring division
    localparam logic [STEP_W-1:0] STEP_LAST = 4'd12;

    // Scaling constants
    localparam logic [SPD_W-1:0] SPEED_MAX = 13'd5000;
    localparam logic [CFG_W-1:0] DAC_DIV   = 16'd5000;
    localparam logic [CFG_W-1:0] ADC_FULL  = 16'd1023;

    // Register values after reset
    localparam logic [15:0] RST_RAMP_UP   = 16'd128;
    localparam logic [15:0] RST_PLATEAU   = 16'd512;
    localparam logic [15:0] RST_RAMP_DOWN = 16'd128;
    localparam logic [15:0] RST_REST      = 16'd64;
    localparam logic [12:0] RST_PLAT_SPD  = 13'd5000;
    localparam logic [7:0]  RST_GAIN      = 8'd2;
    localparam logic [15:0] RST_PWM_LIMIT = 16'd800;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RAMP_UP   = 3'd0,
        CFG_PLATEAU   = 3'd1,
        CFG_RAMP_DOWN = 3'd2,
        CFG_REST      = 3'd3,
        CFG_PLAT_SPD  = 3'd4,
        CFG_GAIN      = 3'd5,
        CFG_PWM_LIMIT = 3'd6
    } t_cfg_idx;

    // Profile phases
    typedef enum logic [1:0] {
        PH_REST = 2'd0,
        PH_UP   = 2'd1,
        PH_PLAT = 2'd2,
        PH_DOWN = 2'd3
    } t_phase;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_TGT,
        ST_DIV_TGT,
        ST_DIV_DAC,
        ST_DIV_MEAS,
        ST_MUL_DRV,
        ST_DONE
    } t_state;

    // Input transaction
    typedef struct packed {
        logic       run_request;
        logic [9:0] speed_sample;
    } t_in;

    // Result transaction
    typedef struct packed {
        logic [12:0] speed_target;
        logic [9:0]  dac_code;
        logic [15:0] pwm_duty;
        logic [1:0]  phase;
    } t_out;

    // target * 1023 as a divider numerator
    function automatic logic [NUM_W-1:0] f_dac_num(input logic [SPD_W-1:0] t);
        return {6'b0, t, 10'b0} - {16'b0, t};
    endfunction

    // sample * 5000 as a divider numerator (5000 = 4096 + 512 + 256 + 128 + 8)
    function automatic logic [NUM_W-1:0] f_meas_num(input logic [9:0] s);
        return {7'b0, s, 12'b0} + {10'b0, s, 9'b0} + {11'b0, s, 8'b0}
             + {12'b0, s, 7'b0} + {16'b0, s, 3'b0};
    endfunction

endpackage

`default_nettype wire

@@ sv/trapezoid_speed_profile_p_control.sv @@
// Top level: trapezoidal speed profile with a proportional speed controller.
`default_nettype none

// One input transaction is one control tick and gives exactly one result. The tick is
// worked through a single shift-add multiplier and a single restoring divider, one
// bit per cycle: on a ramp the setpoint multiply and divide, then the DAC scaling
// divide, the speed sample divide and the gain multiply. A result waiting in the
// output register does not hold up the next tick, only that tick's handover.
// Configuration is written through a plain write port; the user is to write it
// between ticks, which the block itself does not enforce.
module trapezoid_speed_profile_p_control #(
    parameter int TICK_BITS = tspc_pkg::TICK_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output      logic                          o_in_stall,
    input  wire tspc_pkg::t_in                 i_in,
    output      logic                          o_out_valid,
    input  wire logic                          i_out_stall,
    output      tspc_pkg::t_out                o_out,
    input  wire logic                          i_cfg_we,
    input  wire logic [tspc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [tspc_pkg::CFG_W-1:0]    i_cfg_data
);
    import tspc_pkg::*;

    localparam int CMP_W = (TICK_BITS > CFG_W) ? TICK_BITS : CFG_W;
    localparam logic [TICK_BITS-1:0] TICK_MAX = '1;

    // Configuration registers
    logic [CFG_W-1:0] r_ramp_up, r_plateau, r_ramp_down, r_rest, r_pwm_limit;
    logic [SPD_W-1:0] r_plat_spd;
    logic [7:0]       r_gain;

    // Profile state
    t_phase                r_phase, n_phase;
    logic [TICK_BITS-1:0]  r_ticks, n_ticks;
    logic [SPD_W-1:0]      r_target, n_target;

    // Sequencer and arithmetic
    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic [9:0]        r_sample, n_sample;
    logic [CFG_W-1:0]  r_mhi, n_mhi, r_mcand, n_mcand;
    logic [SPD_W-1:0]  r_mlo, n_mlo;
    logic [CFG_W-1:0]  r_rem, n_rem, r_dvsr, n_dvsr;
    logic [SPD_W-1:0]  r_dnum, n_dnum, r_quo, n_quo;
    logic [9:0]        r_dac, n_dac;
    logic [CFG_W-1:0]  r_duty, n_duty;

    // Output register
    logic r_out_valid, n_out_valid;
    t_out r_out, n_out;

    // Combinational helpers
    logic                 in_acc;
    logic [TICK_BITS-1:0] cnt_inc;
    logic [CMP_W-1:0]     cnt_x, inc_x, down_diff;
    logic [SPD_W-1:0]     vp;
    logic [CFG_W:0]       m_sum;
    logic [NUM_W-1:0]     m_prod, num_ld;
    logic [CFG_W:0]       d_t;
    logic                 d_ge;
    logic [CFG_W:0]       d_sub;
    logic [SPD_W-1:0]     d_quo;
    logic [SPD_W:0]       diff;
    logic                 last;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign last        = (r_step == STEP_LAST);

    // Saturate plateau speed and step the tick counter
    assign vp        = (r_plat_spd > SPEED_MAX) ? SPEED_MAX : r_plat_spd;
    assign cnt_inc   = (r_ticks == TICK_MAX) ? r_ticks : r_ticks + 1'b1;
    assign cnt_x     = CMP_W'(r_ticks);
    assign inc_x     = CMP_W'(cnt_inc);
    assign down_diff = CMP_W'(r_ramp_down) - inc_x;

    // Shift-add multiplier step
    assign m_sum  = {1'b0, r_mhi} + (r_mlo[0] ? {1'b0, r_mcand} : '0);
    assign m_prod = {m_sum, r_mlo[SPD_W-1:1]};

    // Restoring divider step
    assign d_t   = {r_rem, r_dnum[SPD_W-1]};
    assign d_ge  = (d_t >= {1'b0, r_dvsr});
    assign d_sub = d_t - {1'b0, r_dvsr};
    assign d_quo = {r_quo[SPD_W-2:0], d_ge};

    // Signed speed error, one bit wider than the setpoint
    assign diff = {1'b0, r_target} - {1'b0, d_quo};

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp_up   <= RST_RAMP_UP;
            r_plateau   <= RST_PLATEAU;
            r_ramp_down <= RST_RAMP_DOWN;
            r_rest      <= RST_REST;
            r_plat_spd  <= RST_PLAT_SPD;
            r_gain      <= RST_GAIN;
            r_pwm_limit <= RST_PWM_LIMIT;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_RAMP_UP:   r_ramp_up   <= i_cfg_data;
                CFG_PLATEAU:   r_plateau   <= i_cfg_data;
                CFG_RAMP_DOWN: r_ramp_down <= i_cfg_data;
                CFG_REST:      r_rest      <= i_cfg_data;
                CFG_PLAT_SPD:  r_plat_spd  <= i_cfg_data[SPD_W-1:0];
                CFG_GAIN:      r_gain      <= i_cfg_data[7:0];
                CFG_PWM_LIMIT: r_pwm_limit <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Hold control state and profile state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_phase     <= PH_REST;
            r_ticks     <= '0;
            r_target    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_phase     <= n_phase;
            r_ticks     <= n_ticks;
            r_target    <= n_target;
            r_out_valid <= n_out_valid;
        end
    end

    // Hold datapath registers
    always_ff @(posedge i_clk) begin
        r_sample <= n_sample;
        r_mhi    <= n_mhi;
        r_mlo    <= n_mlo;
        r_mcand  <= n_mcand;
        r_rem    <= n_rem;
        r_dnum   <= n_dnum;
        r_dvsr   <= n_dvsr;
        r_quo    <= n_quo;
        r_dac    <= n_dac;
        r_duty   <= n_duty;
        r_out    <= n_out;
    end

    // Sequence the tick through phase update, multiplies and divides
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_phase     = r_phase;
        n_ticks     = r_ticks;
        n_target    = r_target;
        n_sample    = r_sample;
        n_mhi       = r_mhi;
        n_mlo       = r_mlo;
        n_mcand     = r_mcand;
        n_rem       = r_rem;
        n_dnum      = r_dnum;
        n_dvsr      = r_dvsr;
        n_quo       = r_quo;
        n_dac       = r_dac;
        n_duty      = r_duty;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        num_ld      = '0;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_sample = i_in.speed_sample;
                    n_step   = '0;
                    // Default: no interpolation, go to DAC scaling
                    n_state  = ST_DIV_DAC;
                    case (r_phase)
                        PH_REST: begin
                            n_target = '0;
                            if (cnt_x >= CMP_W'(r_rest)) begin
                                if (i_in.run_request) begin
                                    n_phase = PH_UP;
                                    n_ticks = '0;
                                end
                            end else begin
                                n_ticks = cnt_inc;
                            end
                        end
                        PH_UP: begin
                            if (cnt_x >= CMP_W'(r_ramp_up)) begin
                                n_phase  = PH_PLAT;
                                n_ticks  = '0;
                                n_target = vp;
                            end else begin
                                n_ticks = cnt_inc;
                                n_mcand = inc_x[CFG_W-1:0];
                                n_dvsr  = r_ramp_up;
                                n_state = ST_MUL_TGT;
                            end
                        end
                        PH_PLAT: begin
                            if (cnt_x >= CMP_W'(r_plateau)) begin
                                n_phase = PH_DOWN;
                                n_ticks = '0;
                            end else begin
                                n_ticks = cnt_inc;
                            end
                        end
                        default: begin
                            if (cnt_x >= CMP_W'(r_ramp_down)) begin
                                n_phase  = PH_REST;
                                n_ticks  = '0;
                                n_target = '0;
                            end else begin
                                n_ticks = cnt_inc;
                                n_mcand = down_diff[CFG_W-1:0];
                                n_dvsr  = r_ramp_down;
                                n_state = ST_MUL_TGT;
                            end
                        end
                    endcase
                    if (n_state == ST_MUL_TGT) begin
                        n_mhi = '0;
                        n_mlo = vp;
                    end else begin
                        num_ld = f_dac_num(n_target);
                        n_rem  = num_ld[NUM_W-1:SPD_W];
                        n_dnum = num_ld[SPD_W-1:0];
                        n_dvsr = DAC_DIV;
                    end
                end
            end

            ST_MUL_TGT: begin
                n_mhi  = m_sum[CFG_W:1];
                n_mlo  = {m_sum[0], r_mlo[SPD_W-1:1]};
                n_step = r_step + 1'b1;
                if (last) begin
                    // Product feeds the divider directly
                    n_rem   = m_prod[NUM_W-1:SPD_W];
                    n_dnum  = m_prod[SPD_W-1:0];
                    n_step  = '0;
                    n_state = ST_DIV_TGT;
                end
            end

            ST_DIV_TGT, ST_DIV_DAC, ST_DIV_MEAS: begin
                n_rem  = d_ge ? d_sub[CFG_W-1:0] : d_t[CFG_W-1:0];
                n_dnum = {r_dnum[SPD_W-2:0], 1'b0};
                n_quo  = d_quo;
                n_step = r_step + 1'b1;
                if (last) begin
                    n_step = '0;
                    case (r_state)
                        ST_DIV_TGT: begin
                            n_target = d_quo;
                            num_ld   = f_dac_num(d_quo);
                            n_rem    = num_ld[NUM_W-1:SPD_W];
                            n_dnum   = num_ld[SPD_W-1:0];
                            n_dvsr   = DAC_DIV;
                            n_state  = ST_DIV_DAC;
                        end
                        ST_DIV_DAC: begin
                            n_dac   = d_quo[9:0];
                            num_ld  = f_meas_num(r_sample);
                            n_rem   = num_ld[NUM_W-1:SPD_W];
                            n_dnum  = num_ld[SPD_W-1:0];
                            n_dvsr  = ADC_FULL;
                            n_state = ST_DIV_MEAS;
                        end
                        default: begin
                            // Negative error drives zero
                            n_mhi   = '0;
                            n_mlo   = diff[SPD_W] ? '0 : diff[SPD_W-1:0];
                            n_mcand = {8'b0, r_gain};
                            n_state = ST_MUL_DRV;
                        end
                    endcase
                end
            end

            ST_MUL_DRV: begin
                n_mhi  = m_sum[CFG_W:1];
                n_mlo  = {m_sum[0], r_mlo[SPD_W-1:1]};
                n_step = r_step + 1'b1;
                if (last) begin
                    // Clamp drive to the PWM limit
                    n_duty  = (m_prod > NUM_W'(r_pwm_limit)) ? r_pwm_limit
                                                              : m_prod[CFG_W-1:0];
                    n_step  = '0;
                    n_state = ST_DONE;
                end
            end

            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.speed_target = r_target;
                    n_out.dac_code     = r_dac;
                    n_out.pwm_duty     = r_duty;
                    n_out.phase        = r_phase;
                    n_out_valid        = 1'b1;
                    n_state            = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Setpoint never exceeds the speed ceiling
    a_target_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_target <= SPEED_MAX)
        else $error("setpoint above speed ceiling");

    // An accepted tick always starts the sequencer
    a_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != ST_IDLE))
        else $error("accepted tick did not start work");

    // Setpoint is zero at rest between ticks
    a_rest_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && r_phase == PH_REST) |-> (r_target == '0))
        else $error("nonzero setpoint at rest");

    // Step counter stays within one operation
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= STEP_LAST)
        else $error("step counter overrun");

    // Delivered duty respects the clamp
    a_duty_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.pwm_duty <= r_pwm_limit))
        else $error("duty above PWM limit");

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// Self-checking testbench for the trapezoid speed profile block with its speed controller.
`timescale 1ns / 100ps

module tb;
    import tspc_pkg::*;

    localparam int HOLD_CYCLES = 500;
    localparam int SHOW_LIMIT  = 10;

    // Clock, reset and block inputs, all known from time zero
    logic                 i_clk    = 1'b0;
    logic                 i_rst_n  = 1'b0;
    logic                 in_valid = 1'b0;
    t_in                  in_data  = '0;
    logic                 out_stall = 1'b0;
    logic                 cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx  = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    logic                 o_in_stall;
    logic                 o_out_valid;
    t_out                 o_out;

    // Predicted register file
    logic [15:0] ramp_up_r   = RST_RAMP_UP;
    logic [15:0] plateau_r   = RST_PLATEAU;
    logic [15:0] ramp_down_r = RST_RAMP_DOWN;
    logic [15:0] rest_r      = RST_REST;
    logic [12:0] plat_spd_r  = RST_PLAT_SPD;
    logic [7:0]  gain_r      = RST_GAIN;
    logic [15:0] pwm_lim_r   = RST_PWM_LIMIT;

    // Predicted profile state
    t_phase      prof_ph    = PH_REST;
    logic [15:0] prof_ticks = '0;
    logic [12:0] prof_tgt   = '0;

    // Expected control outputs, oldest first
    t_out        ctrl_due_q[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req_cnt  = 0;
    int hold_seen     = 0;
    int hold_left     = 0;

    int ticks_sent    = 0;
    int results_seen  = 0;
    int reg_writes    = 0;
    int mismatch_cnt  = 0;
    int phase_seen[4] = '{0, 0, 0, 0};

    trapezoid_speed_profile_p_control dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out       (o_out),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Saturating tick counter
    function automatic logic [15:0] tick_next(input logic [15:0] t);
        return (t == 16'hFFFF) ? t : t + 16'd1;
    endfunction

    // Advance the profile by one tick and work out the control outputs
    function automatic t_out step_profile(input t_in item);
        t_out        r;
        int unsigned cap;
        longint      meas;
        longint      drive;
        cap = (plat_spd_r > SPEED_MAX) ? SPEED_MAX : plat_spd_r;
        case (prof_ph)
            PH_REST: begin
                prof_tgt = '0;
                if (prof_ticks >= rest_r) begin
                    if (item.run_request) begin
                        prof_ph    = PH_UP;
                        prof_ticks = '0;
                    end
                end else begin
                    prof_ticks = tick_next(prof_ticks);
                end
            end
            PH_UP: begin
                if (prof_ticks >= ramp_up_r) begin
                    prof_ph    = PH_PLAT;
                    prof_ticks = '0;
                    prof_tgt   = 13'(cap);
                end else begin
                    prof_ticks = tick_next(prof_ticks);
                    prof_tgt   = 13'((cap * prof_ticks) / ramp_up_r);
                end
            end
            PH_PLAT: begin
                if (prof_ticks >= plateau_r) begin
                    prof_ph    = PH_DOWN;
                    prof_ticks = '0;
                end else begin
                    prof_ticks = tick_next(prof_ticks);
                end
            end
            PH_DOWN: begin
                if (prof_ticks >= ramp_down_r) begin
                    prof_ph    = PH_REST;
                    prof_ticks = '0;
                    prof_tgt   = '0;
                end else begin
                    prof_ticks = tick_next(prof_ticks);
                    prof_tgt   = 13'((cap * (ramp_down_r - prof_ticks)) / ramp_down_r);
                end
            end
        endcase
        // Scale the sample to rpm and clamp the proportional drive
        meas  = (longint'(item.speed_sample) * 5000) / 1023;
        drive = longint'(gain_r) * (longint'(prof_tgt) - meas);
        if (drive > longint'(pwm_lim_r)) drive = longint'(pwm_lim_r);
        if (drive < 0) drive = 0;
        r.speed_target = prof_tgt;
        r.dac_code     = 10'((int'(prof_tgt) * 1023) / 5000);
        r.pwm_duty     = 16'(drive);
        r.phase        = prof_ph;
        return r;
    endfunction

    // Check each result transaction, then predict each accepted tick
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            results_seen++;
            if (ctrl_due_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= SHOW_LIMIT)
                    $display("tb: result with nothing expected: target %0d dac %0d duty %0d ph %0d",
                             o_out.speed_target, o_out.dac_code, o_out.pwm_duty, o_out.phase);
            end else begin
                want = ctrl_due_q.pop_front();
                if (o_out !== want) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= SHOW_LIMIT) begin
                        $write("tb: mismatch at result %0d: target %0d/%0d dac %0d/%0d",
                               results_seen, want.speed_target, o_out.speed_target,
                               want.dac_code, o_out.dac_code);
                        $display(" duty %0d/%0d ph %0d/%0d (expected/actual)",
                                 want.pwm_duty, o_out.pwm_duty, want.phase, o_out.phase);
                    end
                end
            end
        end
        if (i_rst_n && in_valid && !o_in_stall) begin
            want = step_profile(in_data);
            phase_seen[want.phase]++;
            ctrl_due_q.push_back(want);
            ticks_sent++;
        end
    end

    // Result side: random stall, or a long hold when one is requested
    always @(negedge i_clk) begin
        if (hold_req_cnt != hold_seen) begin
            hold_seen = hold_req_cnt;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Offer one tick, with an occasional gap first, and hold it until accepted
    task automatic send_tick(input logic run, input logic [9:0] sample);
        t_in item;
        int  gap;
        item.run_request  = run;
        item.speed_sample = sample;
        @(negedge i_clk);
        if ($urandom_range(99) < send_idle_pct) begin
            gap = $urandom_range(70, 1);
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic drain();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (ctrl_due_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write one register and mirror it in the prediction
    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] val);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        case (idx)
            CFG_RAMP_UP:   ramp_up_r   = val;
            CFG_PLATEAU:   plateau_r   = val;
            CFG_RAMP_DOWN: ramp_down_r = val;
            CFG_REST:      rest_r      = val;
            CFG_PLAT_SPD:  plat_spd_r  = val[12:0];
            CFG_GAIN:      gain_r      = val[7:0];
            CFG_PWM_LIMIT: pwm_lim_r   = val;
            default: ;
        endcase
        reg_writes++;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_profile(input logic [15:0] up, input logic [15:0] plat,
                               input logic [15:0] down, input logic [15:0] rest,
                               input logic [15:0] spd, input logic [15:0] gain,
                               input logic [15:0] lim);
        write_reg(CFG_RAMP_UP, up);
        write_reg(CFG_PLATEAU, plat);
        write_reg(CFG_RAMP_DOWN, down);
        write_reg(CFG_REST, rest);
        write_reg(CFG_PLAT_SPD, spd);
        write_reg(CFG_GAIN, gain);
        write_reg(CFG_PWM_LIMIT, lim);
    endtask

    // Durations: mostly short so the profile cycles, sometimes at the extremes
    function automatic logic [15:0] rand_len(input int unsigned floor_v);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 5)  return 16'(floor_v);
        if (r < 10) return 16'hFFFF;
        if (r < 15) return 16'($urandom_range(65535, floor_v));
        return 16'($urandom_range(24, floor_v));
    endfunction

    function automatic logic [15:0] rand_speed();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10) return 16'd0;
        if (r < 20) return 16'd5000;
        if (r < 25) return 16'($urandom_range(8191, 5001));
        return 16'($urandom_range(5000));
    endfunction

    function automatic logic [15:0] rand_gain();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10) return 16'd0;
        if (r < 20) return 16'd255;
        return 16'($urandom_range(255));
    endfunction

    function automatic logic [15:0] rand_limit();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10) return 16'd0;
        if (r < 20) return 16'hFFFF;
        if (r < 30) return 16'($urandom);
        return 16'($urandom_range(2000));
    endfunction

    function automatic logic [9:0] rand_sample();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10) return 10'd0;
        if (r < 20) return 10'd1023;
        return 10'($urandom_range(1023));
    endfunction

    // Reset values, zero ramps, saturated plateau speed and a short full profile
    task automatic test_directed();
        int k;
        send_tick(1'b0, 10'd0);
        send_tick(1'b0, 10'd1023);
        send_tick(1'b1, 10'h2AA);
        send_tick(1'b0, 10'h155);
        drain();
        // zero-length phases: every phase is left at once
        set_profile(16'd0, 16'd0, 16'd0, 16'd0, 16'd8191, 16'd255, 16'hFFFF);
        send_tick(1'b0, 10'd0);
        send_tick(1'b1, 10'd0);
        send_tick(1'b1, 10'd0);
        send_tick(1'b1, 10'd0);
        send_tick(1'b1, 10'd1023);
        drain();
        // short ramps; a full-scale sample drives the error negative
        set_profile(16'd3, 16'd1, 16'd3, 16'd0, 16'd4999, 16'd1, 16'd800);
        for (k = 0; k < 11; k++)
            send_tick(1'b1, k[0] ? 10'd1023 : 10'd0);
        drain();
    endtask

    // Random register set, then a run of mostly well-formed ticks
    task automatic test_random_profile(input int n_ticks);
        int k;
        set_profile(rand_len(1), rand_len(0), rand_len(1), rand_len(0),
                    rand_speed(), rand_gain(), rand_limit());
        for (k = 0; k < n_ticks; k++)
            send_tick($urandom_range(99) < 92, rand_sample());
        drain();
    endtask

    // Hold off the result side long enough for the block to stall its input
    task automatic test_backpressure();
        int k;
        set_profile(16'd4, 16'd2, 16'd4, 16'd0, 16'd3000, 16'd3, 16'd1500);
        hold_req_cnt++;
        for (k = 0; k < 12; k++)
            send_tick(1'b1, rand_sample());
        drain();
    endtask

    // Longest durations and clamps, then the smallest ones
    task automatic test_config_extremes();
        int k;
        set_profile(16'hFFFF, 16'hFFFF, 16'd1, 16'd0, 16'd5000, 16'd255, 16'hFFFF);
        for (k = 0; k < 30; k++)
            send_tick(1'b1, rand_sample());
        drain();
        set_profile(16'd1, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0);
        for (k = 0; k < 20; k++)
            send_tick(1'b1, rand_sample());
        drain();
    endtask

    // Run limit
    initial begin
        #4000000;
        $display("tb: errors");
        $finish;
    end

    initial begin
        int k;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        // sender mostly busy, result side often stalled
        send_idle_pct = 15;
        recv_idle_pct = 57;
        test_directed();
        for (k = 0; k < 5; k++) test_random_profile(100);

        // roles swapped
        send_idle_pct = 57;
        recv_idle_pct = 15;
        for (k = 0; k < 5; k++) test_random_profile(100);
        test_backpressure();
        test_config_extremes();

        // back to back
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (k = 0; k < 6; k++) test_random_profile(100);

        drain();
        repeat (70) @(posedge i_clk);
        $display("tb: %0d ticks driven, %0d results compared, %0d register writes",
                 ticks_sent, results_seen, reg_writes);
        $display("tb: ticks per phase rest %0d, ramp up %0d, plateau %0d, ramp down %0d",
                 phase_seen[0], phase_seen[1], phase_seen[2], phase_seen[3]);
        if (mismatch_cnt == 0 && ctrl_due_q.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
